>>> src/zone_traversal_counter_unit_assert.svh
// assertion macros for the zone traversal counter checker
`ifndef ZONE_TRAVERSAL_COUNTER_UNIT_ASSERT_SVH
`define ZONE_TRAVERSAL_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ZTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ztc check failed");

// next-cycle implication, disabled while in reset
`define ZTC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ztc check failed");

`endif

>>> src/ztc_pkg.sv
// types, constants and tables shared by the zone traversal counter
package ztc_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int SLOT_W    = 3;
    localparam int TOTAL_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // 10 m^2 expressed in dm^2
    localparam int SIDE_LIMIT = 1000;
    localparam int PROD_W     = 19;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] AVAIL_PRESENT = 2'd1;
    localparam logic [1:0] AVAIL_SKIP    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CORNER0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP    = 3'd4;

    typedef enum logic [2:0] {
        SIDE_LEFT   = 3'd0,
        SIDE_BOTTOM = 3'd1,
        SIDE_RIGHT  = 3'd2,
        SIDE_TOP    = 3'd3,
        SIDE_NONE   = 3'd4
    } ztc_side_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_ENTERED = 2'd1,
        EV_EXITED  = 2'd2,
        EV_GAVE_UP = 2'd3
    } ztc_event_t;

    // side reported for each face of the quadrilateral
    localparam ztc_side_t FACE_SIDE [4] = '{SIDE_LEFT, SIDE_TOP, SIDE_RIGHT, SIDE_BOTTOM};

    typedef struct packed {
        logic signed [7:0] x;
        logic signed [7:0] y;
    } ztc_point_t;

    typedef ztc_point_t [3:0] ztc_corners_t;

    typedef struct packed {
        logic      is_in;
        ztc_side_t side;
    } ztc_geo_t;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] target_slot;
        logic [1:0]        availability;
        logic              frame_empty;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
    } ztc_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_out;
        logic               in_area;
        ztc_event_t         event_res;
        logic [TOTAL_W-1:0] entered_total;
        logic [TOTAL_W-1:0] exited_total;
        logic [TOTAL_W-1:0] gave_up_total;
    } ztc_result_t;

endpackage

>>> src/ztc_face_eval.sv
// cross products of one point against the four faces: inside test and nearest side
module ztc_face_eval
    import ztc_pkg::*;
(
    input  ztc_corners_t corners,
    input  ztc_point_t   point,
    output ztc_geo_t     geo
);

    logic signed [8:0]        fx [4];
    logic signed [8:0]        fy [4];
    logic signed [8:0]        dx [4];
    logic signed [8:0]        dy [4];
    logic signed [17:0]       prod_a [4];
    logic signed [17:0]       prod_b [4];
    logic signed [PROD_W-1:0] prod [4];
    logic signed [PROD_W-1:0] best;
    logic                     take;
    logic                     all_pos;
    ztc_side_t                side;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            fx[k]     = 9'(corners[2'(k + 1)].x) - 9'(corners[k].x);
            fy[k]     = 9'(corners[2'(k + 1)].y) - 9'(corners[k].y);
            dx[k]     = 9'(point.x) - 9'(corners[k].x);
            dy[k]     = 9'(point.y) - 9'(corners[k].y);
            prod_a[k] = 18'(fx[k]) * 18'(dy[k]);
            prod_b[k] = 18'(fy[k]) * 18'(dx[k]);
            prod[k]   = PROD_W'(prod_a[k]) - PROD_W'(prod_b[k]);
        end
    end

    // smallest product wins; the first face may tie the limit
    always_comb
    begin
        best    = PROD_W'(SIDE_LIMIT);
        side    = SIDE_NONE;
        all_pos = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            take = (k == 0) ? (prod[k] <= best) : (prod[k] < best);
            if (take)
            begin
                best = prod[k];
                side = FACE_SIDE[k];
            end
            if (prod[k][PROD_W-1])
            begin
                all_pos = 1'b0;
            end
        end
        geo.is_in = all_pos;
        geo.side  = side;
    end

endmodule

>>> src/ztc_slot_track.sv
// per-slot traversal state, outcome tables and saturating counters
module ztc_slot_track
    import ztc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  ztc_item_t   item,
    input  logic        swap,
    input  ztc_geo_t    geo_earlier,
    input  ztc_geo_t    geo_current,
    output ztc_point_t  earlier_pt,
    output ztc_point_t  current_pt,
    output ztc_result_t result_next
);

    ztc_point_t             current_reg [NUM_SLOTS];
    ztc_point_t             earlier_reg [NUM_SLOTS];
    ztc_side_t              entry_reg   [NUM_SLOTS];
    ztc_side_t              exit_reg    [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   crossed_reg;
    logic [NUM_SLOTS-1:0]   trusted_reg;
    logic [COUNT_BITS-1:0]  entered_reg;
    logic [COUNT_BITS-1:0]  exited_reg;
    logic [COUNT_BITS-1:0]  gave_up_reg;
    logic [COUNT_BITS-1:0]  entered_next;
    logic [COUNT_BITS-1:0]  exited_next;
    logic [COUNT_BITS-1:0]  gave_up_next;

    logic [SLOT_IDX_W-1:0]  idx;
    logic                   active;
    logic                   test_en;
    logic                   was_in;
    logic                   now_in;
    ztc_side_t              en_mid;
    ztc_side_t              ex_mid;
    logic                   cr_mid;
    logic                   tr_mid;
    logic                   counted;
    ztc_event_t             ev;

    function automatic ztc_event_t dir_of(logic plain_entered, logic swp);
        return (plain_entered != swp) ? EV_ENTERED : EV_EXITED;
    endfunction

    function automatic ztc_event_t outcome(logic trusted, ztc_side_t en, ztc_side_t ex,
                                           logic swp);
        ztc_event_t r;
        r = EV_NONE;
        if (!trusted)
        begin
            if (ex == SIDE_TOP)
            begin
                r = dir_of(1'b0, swp);
            end
            else if (ex == SIDE_BOTTOM)
            begin
                r = dir_of(1'b1, swp);
            end
        end
        else
        begin
            unique case (en)
                SIDE_TOP:
                begin
                    unique case (ex)
                        SIDE_BOTTOM: r = dir_of(1'b1, swp);
                        SIDE_TOP:    r = EV_GAVE_UP;
                        SIDE_LEFT:   r = dir_of(1'b0, swp);
                        SIDE_RIGHT:  r = dir_of(1'b1, swp);
                        default:     r = EV_NONE;
                    endcase
                end
                SIDE_BOTTOM: r = (ex == SIDE_TOP) ? dir_of(1'b0, swp) : EV_GAVE_UP;
                SIDE_LEFT:   r = (ex == SIDE_BOTTOM || ex == SIDE_TOP) ?
                                 dir_of(1'b1, swp) : EV_GAVE_UP;
                SIDE_RIGHT:  r = (ex == SIDE_TOP) ? dir_of(1'b0, swp) : EV_GAVE_UP;
                default:     r = EV_NONE;
            endcase
        end
        return r;
    endfunction

    assign idx        = SLOT_IDX_W'(item.target_slot);
    assign active     = !item.action && !item.frame_empty
                        && (int'(item.target_slot) < NUM_SLOTS);
    assign earlier_pt = earlier_reg[idx];
    assign current_pt = current_reg[idx];
    assign test_en    = (item.availability != AVAIL_SKIP);
    assign was_in     = geo_earlier.is_in;
    assign now_in     = geo_current.is_in;

    always_comb
    begin
        en_mid = entry_reg[idx];
        ex_mid = exit_reg[idx];
        cr_mid = crossed_reg[idx];
        tr_mid = trusted_reg[idx];
        if (test_en)
        begin
            if (!was_in && now_in)
            begin
                en_mid = geo_current.side;
                tr_mid = (earlier_pt != '0);
            end
            else if (was_in && !now_in)
            begin
                ex_mid = geo_current.side;
                cr_mid = 1'b1;
            end
        end
        counted = cr_mid && (en_mid != SIDE_NONE) && (ex_mid != SIDE_NONE);
        ev      = counted ? outcome(tr_mid, en_mid, ex_mid, swap) : EV_NONE;
    end

    always_comb
    begin
        entered_next = entered_reg;
        exited_next  = exited_reg;
        gave_up_next = gave_up_reg;
        if (item.action)
        begin
            entered_next = '0;
            exited_next  = '0;
            gave_up_next = '0;
        end
        else if (active)
        begin
            if (ev == EV_ENTERED && entered_reg != COUNT_MAX)
            begin
                entered_next = entered_reg + 1'b1;
            end
            if (ev == EV_EXITED && exited_reg != COUNT_MAX)
            begin
                exited_next = exited_reg + 1'b1;
            end
            if (ev == EV_GAVE_UP && gave_up_reg != COUNT_MAX)
            begin
                gave_up_next = gave_up_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (item.action)
        begin
            result_next.slot_out      = '0;
            result_next.in_area       = 1'b0;
            result_next.event_res     = EV_NONE;
            result_next.entered_total = TOTAL_W'(entered_reg);
            result_next.exited_total  = TOTAL_W'(exited_reg);
            result_next.gave_up_total = TOTAL_W'(gave_up_reg);
        end
        else
        begin
            result_next.slot_out      = item.target_slot;
            result_next.in_area       = active && test_en && now_in;
            result_next.event_res     = active ? ev : EV_NONE;
            result_next.entered_total = TOTAL_W'(entered_next);
            result_next.exited_total  = TOTAL_W'(exited_next);
            result_next.gave_up_total = TOTAL_W'(gave_up_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                current_reg[s] <= '0;
                earlier_reg[s] <= '0;
                entry_reg[s]   <= SIDE_NONE;
                exit_reg[s]    <= SIDE_NONE;
            end
            crossed_reg <= '0;
            trusted_reg <= '0;
            entered_reg <= '0;
            exited_reg  <= '0;
            gave_up_reg <= '0;
        end
        else if (fire)
        begin
            entered_reg <= entered_next;
            exited_reg  <= exited_next;
            gave_up_reg <= gave_up_next;
            if (active)
            begin
                entry_reg[idx]   <= counted ? SIDE_NONE : en_mid;
                exit_reg[idx]    <= counted ? SIDE_NONE : ex_mid;
                crossed_reg[idx] <= counted ? 1'b0 : cr_mid;
                trusted_reg[idx] <= tr_mid;
                earlier_reg[idx] <= (item.availability == AVAIL_PRESENT) ?
                                    current_reg[idx] : '0;
                current_reg[idx] <= '{x: item.pos_x, y: item.pos_y};
            end
        end
    end

endmodule

>>> src/zone_traversal_counter_unit.sv
// top level of the zone traversal counter: config registers and item pipeline
//
//  channel  | signals                                | moves
//  ---------+----------------------------------------+---------------------------
//  item     | item_valid, item_ready, item           | one slot report or read
//  result   | result_valid, result_ready, result     | one result per item
//  config   | cfg_we, cfg_index, cfg_data            | register write, no wait
//
// an item is taken into the input register, evaluated against the slot state
// and lands in the result register
// one item per cycle sustained while results are taken; the result register stalls
// the input register only while a result waits and a new one is ready to move
// reset clears config, pipeline valids, all slot state and the counters at once
module zone_traversal_counter_unit
    import ztc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  ztc_item_t            item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output ztc_result_t          result
);

    ztc_corners_t corners_reg;
    logic         swap_reg;

    logic         stage_valid_reg;
    logic         stage_valid_next;
    ztc_item_t    stage_item_reg;
    logic         res_valid_reg;
    logic         res_valid_next;
    ztc_result_t  res_reg;

    logic         advance;
    ztc_point_t   earlier_pt;
    ztc_point_t   current_pt;
    ztc_geo_t     geo_earlier;
    ztc_geo_t     geo_current;
    ztc_result_t  result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corners_reg <= '0;
            swap_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CORNER0: corners_reg[0] <= ztc_point_t'(cfg_data);
                REG_CORNER1: corners_reg[1] <= ztc_point_t'(cfg_data);
                REG_CORNER2: corners_reg[2] <= ztc_point_t'(cfg_data);
                REG_CORNER3: corners_reg[3] <= ztc_point_t'(cfg_data);
                REG_SWAP:    swap_reg       <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign advance    = stage_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = item_ready ? item_valid : stage_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_item_reg <= item;
        end
        if (advance)
        begin
            res_reg <= result_next;
        end
    end

    ztc_face_eval u_eval_earlier (
        .corners (corners_reg),
        .point   (earlier_pt),
        .geo     (geo_earlier)
    );

    ztc_face_eval u_eval_current (
        .corners (corners_reg),
        .point   (current_pt),
        .geo     (geo_current)
    );

    ztc_slot_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .item        (stage_item_reg),
        .swap        (swap_reg),
        .geo_earlier (geo_earlier),
        .geo_current (geo_current),
        .earlier_pt  (earlier_pt),
        .current_pt  (current_pt),
        .result_next (result_next)
    );

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

>>> src/ztc_checker.sv
// port-level checks for the zone traversal counter, bound to the top level
`include "zone_traversal_counter_unit_assert.svh"

module ztc_checker
    import ztc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_ready,
    input ztc_result_t          result
);

    // totals could wrap to zero only if the counters were wider than the port
    localparam bit TOTALS_EXACT = (COUNT_BITS <= TOTAL_W);

    logic res_stalled;
    logic gave_up_shown;
    logic dir_shown;

    assign res_stalled   = result_valid && !result_ready;
    assign gave_up_shown = (result.event_res != EV_GAVE_UP) || (result.gave_up_total != '0);
    assign dir_shown     = (result.event_res != EV_ENTERED || result.entered_total != '0)
                           && (result.event_res != EV_EXITED || result.exited_total != '0);

    // a stalled result stays and holds its payload
`ZTC_ASSERT_NXT(a_result_hold, clk, rst_n, res_stalled, result_valid && $stable(result))

    // nothing can reach the result register in the first cycle out of reset
`ZTC_ASSERT_IMP(a_reset_empty, clk, rst_n, $rose(rst_n), !result_valid)

    // a counted item's total has just been bumped, so it cannot read zero
`ZTC_ASSERT_IMP(a_gave_up_total, clk, rst_n, result_valid && TOTALS_EXACT, gave_up_shown)

`ZTC_ASSERT_IMP(a_dir_total, clk, rst_n, result_valid && TOTALS_EXACT, dir_shown)

endmodule

bind zone_traversal_counter_unit ztc_checker u_ztc_checker (.*);
